### design/tcc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the text console cursor controller.
package tcc_pkg;

  typedef enum logic [1:0] {
    OP_DRAW   = 2'd0,
    OP_UNMARK = 2'd1,
    OP_MARK   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_MARK  = 2'd1,
    PH_DRAW  = 2'd2
  } phase_t;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [2:0] TAB_ZERO = 3'b000;

  typedef struct packed {
    logic   emit;
    logic   done;
    phase_t phase_next;
  } step_ctrl_t;

endpackage

### design/tcc_step.sv
`timescale 1ns / 1ps
// Per-cycle step logic: one drawing op and the cursor update for the held item.
module tcc_step #(
  parameter int COLUMNS = 21,
  parameter int ROWS    = 8,
  localparam int COL_W  = $clog2(COLUMNS),
  localparam int ROW_W  = $clog2(ROWS)
) (
  input  logic               action,
  input  logic [7:0]         char_code,
  input  logic [COL_W-1:0]   target_col,
  input  logic [ROW_W-1:0]   target_row,
  input  tcc_pkg::phase_t    phase,
  input  logic [COL_W-1:0]   cursor_col,
  input  logic [ROW_W-1:0]   cursor_row,
  output tcc_pkg::step_ctrl_t ctrl,
  output logic [COL_W-1:0]   col_next,
  output logic [ROW_W-1:0]   row_next,
  output tcc_pkg::op_t       res_op,
  output logic [COL_W-1:0]   res_col,
  output logic [ROW_W-1:0]   res_row,
  output logic [6:0]         res_glyph
);

  logic [COL_W:0]   col_inc;
  logic             col_wrap;
  logic [COL_W-1:0] col_after;
  logic [ROW_W-1:0] row_inc;
  logic [ROW_W-1:0] row_prev;
  logic [ROW_W-1:0] row_after;
  logic             tab_stop;
  logic [7:0]       c_minus;
  logic [6:0]       glyph_val;

  assign col_inc   = {1'b0, cursor_col} + (COL_W+1)'(1);
  assign col_wrap  = col_inc >= (COL_W+1)'(COLUMNS);
  assign col_after = col_wrap ? '0 : col_inc[COL_W-1:0];
  assign row_inc   = (cursor_row == ROW_W'(ROWS - 1)) ? '0 : cursor_row + ROW_W'(1);
  assign row_prev  = (cursor_row == '0) ? ROW_W'(ROWS - 1) : cursor_row - ROW_W'(1);
  assign row_after = col_wrap ? row_inc : cursor_row;
  assign tab_stop  = cursor_col[2:0] == tcc_pkg::TAB_ZERO;
  assign c_minus   = char_code - tcc_pkg::CH_SPACE;
  assign glyph_val = (char_code < tcc_pkg::CH_SPACE || char_code[7]) ? '0 : c_minus[6:0];

  always_comb begin
    ctrl.emit       = 1'b0;
    ctrl.done       = 1'b1;
    ctrl.phase_next = tcc_pkg::PH_FIRST;
    col_next        = cursor_col;
    row_next        = cursor_row;
    res_op          = tcc_pkg::OP_DRAW;
    res_col         = cursor_col;
    res_row         = cursor_row;
    res_glyph       = glyph_val;
    if (action) begin
      col_next = (target_col > COL_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : target_col;
      row_next = (target_row > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : target_row;
    end else begin
      case (char_code)
        tcc_pkg::CH_TAB: begin
          if (!tab_stop) begin
            ctrl.emit = 1'b1;
            ctrl.done = col_wrap || (col_inc[2:0] == tcc_pkg::TAB_ZERO);
            res_glyph = '0;
            col_next  = col_after;
            row_next  = row_after;
          end
        end
        tcc_pkg::CH_LF: begin
          col_next = '0;
          row_next = row_inc;
        end
        tcc_pkg::CH_CR: begin
          col_next = '0;
        end
        default: begin
          ctrl.emit = 1'b1;
          unique case (phase)
            tcc_pkg::PH_FIRST: begin
              if (cursor_col == '0) begin
                ctrl.done       = 1'b0;
                ctrl.phase_next = tcc_pkg::PH_MARK;
                res_op          = tcc_pkg::OP_UNMARK;
                res_col         = '0;
                res_row         = row_prev;
                res_glyph       = '0;
              end else begin
                col_next = col_after;
                row_next = row_after;
              end
            end
            tcc_pkg::PH_MARK: begin
              ctrl.done       = 1'b0;
              ctrl.phase_next = tcc_pkg::PH_DRAW;
              res_op          = tcc_pkg::OP_MARK;
              res_col         = '0;
              res_glyph       = '0;
            end
            default: begin
              col_next = col_after;
              row_next = row_after;
            end
          endcase
        end
      endcase
    end
  end

endmodule

### design/text_console_cursor_top.sv
`timescale 1ns / 1ps
// An accepted item sits in the input register; each result beat is registered.
// Throughput: one result beat per cycle unless the result side stalls; an item holds
//   the input register until its last beat issues (glyph 1 or 3, tab 0 to 7 spaces).
// Items with no result (move, CR, LF, tab on a stop) never wait on the result side.
// Reset: synchronous; cursor goes to row 0, column 0 and pending beats drop.
// Top level of the text console cursor controller.
module text_console_cursor_top #(
  parameter int COLUMNS = 21,
  parameter int ROWS    = 8,
  localparam int COL_W  = $clog2(COLUMNS),
  localparam int ROW_W  = $clog2(ROWS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             action,
  input  logic [7:0]       char_code,
  input  logic [COL_W-1:0] target_col,
  input  logic [ROW_W-1:0] target_row,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       op,
  output logic [COL_W-1:0] text_col,
  output logic [ROW_W-1:0] text_row,
  output logic [6:0]       glyph,
  output logic             last
);

  logic             iv;
  logic             i_action;
  logic [7:0]       i_char;
  logic [COL_W-1:0] i_tcol;
  logic [ROW_W-1:0] i_trow;
  tcc_pkg::phase_t  phase;
  logic [COL_W-1:0] cursor_col;
  logic [ROW_W-1:0] cursor_row;

  tcc_pkg::step_ctrl_t ctrl;
  logic [COL_W-1:0]    col_next;
  logic [ROW_W-1:0]    row_next;
  tcc_pkg::op_t        res_op;
  logic [COL_W-1:0]    res_col;
  logic [ROW_W-1:0]    res_row;
  logic [6:0]          res_glyph;

  logic out_free;
  logic adv;
  logic in_fire;

  tcc_step #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_step (
    .action    (i_action),
    .char_code (i_char),
    .target_col(i_tcol),
    .target_row(i_trow),
    .phase     (phase),
    .cursor_col(cursor_col),
    .cursor_row(cursor_row),
    .ctrl      (ctrl),
    .col_next  (col_next),
    .row_next  (row_next),
    .res_op    (res_op),
    .res_col   (res_col),
    .res_row   (res_row),
    .res_glyph (res_glyph)
  );

  assign out_free = !out_valid || out_ready;
  assign adv      = iv && (!ctrl.emit || out_free);
  assign in_ready = !iv || (adv && ctrl.done);
  assign in_fire  = in_valid && in_ready;

  // phase returns to PH_FIRST on the closing step of every item
  always_ff @(posedge clk) begin
    if (rst) begin
      iv         <= 1'b0;
      phase      <= tcc_pkg::PH_FIRST;
      cursor_col <= '0;
      cursor_row <= '0;
    end else begin
      if (adv) begin
        cursor_col <= col_next;
        cursor_row <= row_next;
        phase      <= ctrl.phase_next;
      end
      if (in_fire) begin
        iv <= 1'b1;
      end else if (adv && ctrl.done) begin
        iv <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      i_action <= action;
      i_char   <= char_code;
      i_tcol   <= target_col;
      i_trow   <= target_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctrl.emit) begin
      op       <= res_op;
      text_col <= res_col;
      text_row <= res_row;
      glyph    <= res_glyph;
      last     <= ctrl.done;
    end
  end

  // cursor stays on the grid
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    cursor_col <= COL_W'(COLUMNS - 1))
    else $error("cursor column off grid");

  // an unmark beat is never last; a mark beat of the same item follows it
  a_unmark_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && op == tcc_pkg::OP_UNMARK |-> !last)
    else $error("unmark flagged as last");

  // row ops carry column 0 and glyph 0
  a_row_op_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (op == tcc_pkg::OP_UNMARK || op == tcc_pkg::OP_MARK)
      |-> text_col == '0 && glyph == '0)
    else $error("row op with nonzero column or glyph");

  // a stalled item stays held and keeps its phase
  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    iv && !adv |=> iv && $stable(phase) && $stable(cursor_col))
    else $error("held item lost while stalled");

endmodule

### bench/console_op_checker.sv
`timescale 1ns / 1ps
// Checker for the text console cursor controller: predicts drawing ops and scores result beats.
module console_op_checker #(
  parameter int COLUMNS = 21,
  parameter int ROWS    = 8,
  localparam int COL_W  = $clog2(COLUMNS),
  localparam int ROW_W  = $clog2(ROWS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic             action,
  input  logic [7:0]       char_code,
  input  logic [COL_W-1:0] target_col,
  input  logic [ROW_W-1:0] target_row,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [1:0]       op,
  input  logic [COL_W-1:0] text_col,
  input  logic [ROW_W-1:0] text_row,
  input  logic [6:0]       glyph,
  input  logic             last,
  output int               fail_count,
  output int               pending,
  output int               beats_checked
);

  localparam int MAX_OPS = 7;

  typedef struct {
    tcc_pkg::op_t     op;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [6:0]       glyph;
    logic             last;
  } draw_op_t;

  draw_op_t         expected_ops[$];
  draw_op_t         want;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;

  initial begin
    fail_count    = 0;
    pending       = 0;
    beats_checked = 0;
    cur_col       = '0;
    cur_row       = '0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] checker: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic void advance_row();
    cur_row = ROW_W'((int'(cur_row) + 1) % ROWS);
    cur_col = '0;
  endfunction

  task automatic predict_console_ops(input logic act, input logic [7:0] ch,
                                     input logic [COL_W-1:0] tc,
                                     input logic [ROW_W-1:0] tr);
    draw_op_t   ops[MAX_OPS];
    int         n;
    logic [6:0] g;
    n = 0;
    if (act) begin
      cur_col = (int'(tc) > COLUMNS - 1) ? COL_W'(COLUMNS - 1) : tc;
      cur_row = (int'(tr) > ROWS - 1) ? ROW_W'(ROWS - 1) : tr;
    end else if (ch == tcc_pkg::CH_TAB) begin
      while (cur_col[2:0] != tcc_pkg::TAB_ZERO && int'(cur_col) < COLUMNS) begin
        ops[n] = '{tcc_pkg::OP_DRAW, cur_col, cur_row, 7'd0, 1'b0};
        n++;
        cur_col++;
      end
      if (int'(cur_col) >= COLUMNS) advance_row();
    end else if (ch == tcc_pkg::CH_LF) begin
      advance_row();
    end else if (ch == tcc_pkg::CH_CR) begin
      cur_col = '0;
    end else begin
      g = (ch < tcc_pkg::CH_SPACE || ch[7]) ? 7'd0 : 7'(ch - tcc_pkg::CH_SPACE);
      if (cur_col == '0) begin
        // new line: drop marker on the row above, mark and blank this one
        ops[n] = '{tcc_pkg::OP_UNMARK, '0,
                   ROW_W'((int'(cur_row) + ROWS - 1) % ROWS), 7'd0, 1'b0};
        n++;
        ops[n] = '{tcc_pkg::OP_MARK, '0, cur_row, 7'd0, 1'b0};
        n++;
      end
      ops[n] = '{tcc_pkg::OP_DRAW, cur_col, cur_row, g, 1'b0};
      n++;
      cur_col++;
      if (int'(cur_col) >= COLUMNS) advance_row();
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) ops[i].last = 1'b1;
      expected_ops.push_back(ops[i]);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cur_col = '0;
      cur_row = '0;
      expected_ops.delete();
    end else begin
      // retire the output beat first; it can only belong to older input beats
      if (out_valid && out_ready) begin
        if (expected_ops.size() == 0) begin
          report_mismatch($sformatf("unexpected beat op=%0d col=%0d row=%0d glyph=%0d last=%0d",
                                    op, text_col, text_row, glyph, last));
        end else begin
          want = expected_ops.pop_front();
          if (op != want.op)
            report_mismatch($sformatf("beat %0d op %0d, want %0d",
                                      beats_checked, op, want.op));
          if (text_col != want.col)
            report_mismatch($sformatf("beat %0d text_col %0d, want %0d",
                                      beats_checked, text_col, want.col));
          if (text_row != want.row)
            report_mismatch($sformatf("beat %0d text_row %0d, want %0d",
                                      beats_checked, text_row, want.row));
          if (glyph != want.glyph)
            report_mismatch($sformatf("beat %0d glyph %0d, want %0d",
                                      beats_checked, glyph, want.glyph));
          if (last != want.last)
            report_mismatch($sformatf("beat %0d last %0d, want %0d",
                                      beats_checked, last, want.last));
          beats_checked++;
        end
      end
      if (in_valid && in_ready)
        predict_console_ops(action, char_code, target_col, target_row);
    end
    pending = expected_ops.size();
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// Top of the bench: clock, reset, console byte and cursor move stimulus, and the verdict.
module testbench;

  localparam int COLUMNS   = 21;
  localparam int ROWS      = 8;
  localparam int COL_W     = $clog2(COLUMNS);
  localparam int ROW_W     = $clog2(ROWS);
  localparam int LONG_HOLD = 200;
  localparam int DRAIN     = 20;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic             action;
  logic [7:0]       char_code;
  logic [COL_W-1:0] target_col;
  logic [ROW_W-1:0] target_row;
  logic             out_valid;
  logic             out_ready;
  logic [1:0]       op;
  logic [COL_W-1:0] text_col;
  logic [ROW_W-1:0] text_row;
  logic [6:0]       glyph;
  logic             last;

  int   fail_count;
  int   pending;
  int   beats_checked;
  int   bytes_sent;
  int   moves_sent;
  int   tabs_sent;
  int   breaks_sent;
  logic tx_steady;
  logic rx_steady;
  logic hold_req;

  text_console_cursor_top #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .char_code(char_code),
    .target_col(target_col), .target_row(target_row),
    .out_valid(out_valid), .out_ready(out_ready),
    .op(op), .text_col(text_col), .text_row(text_row),
    .glyph(glyph), .last(last)
  );

  console_op_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .char_code(char_code),
    .target_col(target_col), .target_row(target_row),
    .out_valid(out_valid), .out_ready(out_ready),
    .op(op), .text_col(text_col), .text_row(text_row),
    .glyph(glyph), .last(last),
    .fail_count(fail_count), .pending(pending), .beats_checked(beats_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d ops outstanding", pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // mostly short idle stretches, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: random back-pressure, plus one long hold on request
  initial begin : rx_side
    int idle_left;
    int held;
    idle_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        for (held = 1; held < LONG_HOLD; held++) @(posedge clk);
      end else if (rx_steady) begin
        out_ready <= 1'b1;
      end else if (idle_left > 0) begin
        out_ready <= 1'b0;
        idle_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) idle_left = pick_gap();
      end
    end
  end

  task automatic send_item(input logic act, input logic [7:0] ch,
                           input logic [COL_W-1:0] tc, input logic [ROW_W-1:0] tr);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    char_code  <= ch;
    target_col <= tc;
    target_row <= tr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (act) moves_sent++;
    else begin
      bytes_sent++;
      if (ch == tcc_pkg::CH_TAB) tabs_sent++;
      if (ch == tcc_pkg::CH_LF || ch == tcc_pkg::CH_CR) breaks_sent++;
    end
  endtask

  task automatic send_byte(input logic [7:0] ch);
    send_item(1'b0, ch, COL_W'($urandom), ROW_W'($urandom));
  endtask

  task automatic send_move(input int col, input int row);
    send_item(1'b1, 8'($urandom), COL_W'(col), ROW_W'(row));
  endtask

  // mostly printable text with tabs and line breaks, some moves and odd bytes
  task automatic send_random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 58)      send_byte(8'($urandom_range(8'h20, 8'h7F)));
    else if (r < 68) send_byte(tcc_pkg::CH_TAB);
    else if (r < 75) send_byte(tcc_pkg::CH_LF);
    else if (r < 80) send_byte(tcc_pkg::CH_CR);
    else if (r < 85) send_byte(8'($urandom_range(8'h00, 8'h1F)));
    else if (r < 90) send_byte(8'($urandom_range(8'h80, 8'hFF)));
    else             send_move($urandom_range(0, 31), $urandom_range(0, 7));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin : stimulus
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    action      <= 1'b0;
    char_code   <= '0;
    target_col  <= '0;
    target_row  <= '0;
    tx_steady   = 1'b0;
    rx_steady   = 1'b0;
    hold_req    = 1'b0;
    bytes_sent  = 0;
    moves_sent  = 0;
    tabs_sent   = 0;
    breaks_sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: line start from row 0, substitutes, glyph range ends
    send_byte(8'h41);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(tcc_pkg::CH_SPACE);
    send_byte(8'h1F);
    send_byte(tcc_pkg::CH_TAB);   // one space to column 8
    send_byte(tcc_pkg::CH_TAB);   // already on a stop
    send_move(31, 7);             // saturates to the last column
    send_byte(8'h5A);             // wraps to row 0
    send_move(19, 6);
    send_byte(tcc_pkg::CH_TAB);   // runs into the right edge
    send_move(1, 0);
    send_byte(tcc_pkg::CH_TAB);   // longest space run
    send_byte(8'h7E);
    send_byte(tcc_pkg::CH_CR);
    send_byte(8'h61);             // column 0 again after CR
    send_byte(tcc_pkg::CH_LF);
    send_byte(8'h0B);
    send_move(17, 3);
    send_byte(tcc_pkg::CH_TAB);
    send_move(0, 0);
    send_byte(8'h30);
    wait_drained();

    repeat (150) send_random_item();

    tx_steady = 1'b1;
    rx_steady = 1'b1;
    repeat (60) send_random_item();
    rx_steady = 1'b0;

    // hold the result side while text keeps coming so the input stalls
    hold_req = 1'b1;
    repeat (40) send_byte(8'($urandom_range(8'h21, 8'h7E)));
    tx_steady = 1'b0;
    wait_drained();

    repeat (100) send_random_item();

    wait_drained();
    repeat (DRAIN) @(posedge clk);

    $display("covered %0d console bytes (%0d tabs, %0d CR/LF) and %0d cursor moves",
             bytes_sent, tabs_sent, breaks_sent, moves_sent);
    $display("checked %0d drawing op beats under random and long back-pressure",
             beats_checked);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
design/tcc_pkg.sv
design/tcc_step.sv
design/text_console_cursor_top.sv
bench/console_op_checker.sv
bench/testbench.sv
